@@ src/lps_pkg.sv @@
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants for the LED pattern sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int LED_COUNT    = 8;
    localparam int HALF_COUNT   = LED_COUNT / 2;
    localparam int STEP_SLOTS   = 6;
    localparam int MODE_W       = 3;
    localparam int IDX_W        = 3;
    localparam int INTERVAL_W   = 16;

    typedef logic [LED_COUNT-1:0]  led_t;
    typedef logic [MODE_W-1:0]     mode_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [INTERVAL_W-1:0] interval_t;

    localparam interval_t INTERVAL_RESET = 16'd200;
    localparam interval_t ELAPSED_MAX    = 16'hffff;

    localparam mode_t MODE_ALL_ON       = 3'd0;
    localparam mode_t MODE_ALL_OFF      = 3'd1;
    localparam mode_t MODE_FLOWER_OPEN  = 3'd2;
    localparam mode_t MODE_FLOWER_CLOSE = 3'd3;
    localparam mode_t MODE_DOT_UP       = 3'd4;
    localparam mode_t MODE_DOT_DOWN     = 3'd5;
    localparam mode_t MODE_FILL_UP      = 3'd6;
    localparam mode_t MODE_FILL_DOWN    = 3'd7;

    localparam led_t LED_ALL   = 8'hff;
    localparam led_t LED_NONE  = 8'h00;
    localparam led_t LED_LOW   = 8'h01;
    localparam led_t LED_HIGH  = 8'h80;
    localparam led_t LED_MID_L = 8'h08;
    localparam led_t LED_MID_H = 8'h10;

endpackage

@@ src/led_pattern_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// led_pattern_sequencer_unit
// Eight-LED chaser: button items cycle modes, tick items pace the steps.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------
//  input    | in_valid / in_ready       | ms_tick, press_event
//  output   | out_valid / out_ready     | led_bits, mode
//  config   | cfg_wr_en                 | cfg_wr_data (step interval)
//
//  One item per cycle unless the output stalls; result appears in the cycle
//  after accept, set by the single state update path into the result register.
//  in_ready is high while the result register is empty or being taken.
//  Reset: interval 200, all counters, mode and LEDs zero.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                ms_tick,
    input  logic                press_event,
    output logic                out_valid,
    input  logic                out_ready,
    output lps_pkg::led_t       led_bits,
    output lps_pkg::mode_t      mode,
    input  logic                cfg_wr_en,
    input  lps_pkg::interval_t  cfg_wr_data
);
    import lps_pkg::*;

    interval_t interval_reg;
    interval_t elapsed_reg;
    interval_t elapsed_next;
    mode_t     mode_reg;
    mode_t     mode_next;
    logic      started_reg;
    idx_t      idx_reg [STEP_SLOTS];
    led_t      led_reg;
    led_t      led_next;
    led_t      led_base;
    logic      out_valid_reg;
    logic      in_fire;
    logic      do_step;
    logic      stepping;
    logic [2:0] slot;
    interval_t elapsed_inc;
    led_t      step_led;
    idx_t      step_idx;
    idx_t      idx_sel;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign led_bits  = led_reg;
    assign mode      = mode_reg;

    always_comb
    begin
        mode_next = mode_reg;
        if (press_event)
        begin
            mode_next = started_reg ? mode_reg + mode_t'(1) : MODE_ALL_ON;
        end
    end

    assign elapsed_inc  = (ms_tick && elapsed_reg != ELAPSED_MAX) ? elapsed_reg + 16'd1
                                                                  : elapsed_reg;
    assign do_step      = elapsed_inc >= interval_reg;
    assign elapsed_next = do_step ? '0 : elapsed_inc;
    assign stepping     = mode_next >= MODE_FLOWER_OPEN;
    assign slot         = mode_next - MODE_FLOWER_OPEN;
    assign idx_sel      = stepping ? idx_reg[slot] : '0;
    assign led_base     = started_reg ? led_reg : LED_NONE;

    lps_step u_step (
        .mode_cur (mode_next),
        .idx_cur  (idx_sel),
        .led_cur  (led_base),
        .led_new  (step_led),
        .idx_new  (step_idx)
    );

    assign led_next = do_step ? step_led : led_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= INTERVAL_RESET;
            elapsed_reg   <= '0;
            mode_reg      <= MODE_ALL_ON;
            started_reg   <= 1'b0;
            led_reg       <= LED_NONE;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < STEP_SLOTS; k++)
            begin
                idx_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                interval_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                elapsed_reg   <= elapsed_next;
                mode_reg      <= mode_next;
                started_reg   <= started_reg || press_event;
                led_reg       <= led_next;
                out_valid_reg <= 1'b1;
                if (do_step && stepping)
                begin
                    idx_reg[slot] <= step_idx;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted item produced no result");

    a_mode_before_start: assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> (mode_reg == MODE_ALL_ON && led_reg == LED_NONE ||
                          mode_reg == MODE_ALL_ON && led_reg == LED_ALL))
        else $error("mode or LEDs moved before first press");

    a_counter_below_interval: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !cfg_wr_en |=> (elapsed_reg < interval_reg || elapsed_reg == '0))
        else $error("counter left at or above interval");

endmodule

@@ src/lps_step.sv @@
// ----------------------------------------------------------------------------
// lps_step
// One pattern step: next LED value and next step index for the active mode.
// ----------------------------------------------------------------------------
module lps_step (
    input  lps_pkg::mode_t mode_cur,
    input  lps_pkg::idx_t  idx_cur,
    input  lps_pkg::led_t  led_cur,
    output lps_pkg::led_t  led_new,
    output lps_pkg::idx_t  idx_new
);
    import lps_pkg::*;

    logic  half;
    idx_t  i;
    idx_t  i_inc;
    led_t  base_clr;
    led_t  base_set;

    assign half     = (mode_cur == MODE_FLOWER_OPEN) || (mode_cur == MODE_FLOWER_CLOSE);
    assign i        = half ? {1'b0, idx_cur[1:0]} : idx_cur;
    assign i_inc    = i + idx_t'(1);
    assign idx_new  = half ? {1'b0, i_inc[1:0]} : i_inc;
    assign base_clr = (i == '0) ? LED_NONE : led_cur;
    assign base_set = (i == '0) ? LED_ALL : led_cur;

    always_comb
    begin
        unique case (mode_cur)
            MODE_ALL_ON:       led_new = LED_ALL;
            MODE_ALL_OFF:      led_new = LED_NONE;
            MODE_FLOWER_OPEN:  led_new = base_clr | (LED_MID_L >> i) | (LED_MID_H << i);
            MODE_FLOWER_CLOSE: led_new = base_set & ~((LED_LOW << i) | (LED_HIGH >> i));
            MODE_DOT_UP:       led_new = LED_LOW << i;
            MODE_DOT_DOWN:     led_new = LED_HIGH >> i;
            MODE_FILL_UP:      led_new = base_clr | (LED_LOW << i);
            MODE_FILL_DOWN:    led_new = base_clr | (LED_HIGH >> i);
            default:           led_new = LED_NONE;
        endcase
    end

endmodule

@@ verif/tb_led_pattern_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_led_pattern_sequencer_unit
// Self-checking bench for the LED chaser. Items go in with random gaps and
// random output stalls. A scoreboard keeps its own copy of the mode, the step
// counter and the per-mode pattern positions, and checks every LED/mode
// result in order. Covers the phase before the first press, every mode with
// wrap, zero and minimum intervals, the largest interval, and a lowered
// interval.
// ----------------------------------------------------------------------------
typedef struct packed {
    lps_pkg::led_t  leds;
    lps_pkg::mode_t mode_v;
} lamp_state_t;

class lamp_scoreboard;
    lps_pkg::interval_t interval;
    lps_pkg::interval_t elapsed;
    lps_pkg::mode_t     cur_mode;
    bit                 started;
    lps_pkg::idx_t      step_idx [lps_pkg::STEP_SLOTS];
    lps_pkg::led_t      leds;
    lamp_state_t        expected_q [$];
    int                 errors;

    function new();
        interval = lps_pkg::INTERVAL_RESET;
        elapsed  = '0;
        cur_mode = lps_pkg::MODE_ALL_ON;
        started  = 1'b0;
        leds     = lps_pkg::LED_NONE;
        errors   = 0;
        foreach (step_idx[k])
        begin
            step_idx[k] = '0;
        end
    endfunction

    function void set_interval(lps_pkg::interval_t v);
        interval = v;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void step_pattern();
        int            slot;
        lps_pkg::idx_t i;
        case (cur_mode)
            lps_pkg::MODE_ALL_ON:  leds = lps_pkg::LED_ALL;
            lps_pkg::MODE_ALL_OFF: leds = lps_pkg::LED_NONE;
            default:
            begin
                slot = int'(cur_mode) - 2;
                i    = step_idx[slot];
                case (cur_mode)
                    lps_pkg::MODE_FLOWER_OPEN:
                    begin
                        if (i == 0)
                            leds = lps_pkg::LED_NONE;
                        leds |= (lps_pkg::LED_MID_L >> i) | (lps_pkg::LED_MID_H << i);
                    end
                    lps_pkg::MODE_FLOWER_CLOSE:
                    begin
                        if (i == 0)
                            leds = lps_pkg::LED_ALL;
                        leds &= ~((lps_pkg::LED_LOW << i) | (lps_pkg::LED_HIGH >> i));
                    end
                    lps_pkg::MODE_DOT_UP:   leds = lps_pkg::LED_LOW << i;
                    lps_pkg::MODE_DOT_DOWN: leds = lps_pkg::LED_HIGH >> i;
                    lps_pkg::MODE_FILL_UP:
                    begin
                        if (i == 0)
                            leds = lps_pkg::LED_NONE;
                        leds |= lps_pkg::LED_LOW << i;
                    end
                    default:
                    begin
                        if (i == 0)
                            leds = lps_pkg::LED_NONE;
                        leds |= lps_pkg::LED_HIGH >> i;
                    end
                endcase
                if (cur_mode == lps_pkg::MODE_FLOWER_OPEN ||
                    cur_mode == lps_pkg::MODE_FLOWER_CLOSE)
                    step_idx[slot] = lps_pkg::idx_t'((int'(i) + 1) % lps_pkg::HALF_COUNT);
                else
                    step_idx[slot] = lps_pkg::idx_t'((int'(i) + 1) % lps_pkg::LED_COUNT);
            end
        endcase
    endfunction

    function void note_item(logic tick, logic press);
        lamp_state_t exp_item;
        if (!started)
            leds = lps_pkg::LED_NONE;
        if (press)
        begin
            cur_mode = started ? lps_pkg::mode_t'(cur_mode + 1'b1) : lps_pkg::MODE_ALL_ON;
            started  = 1'b1;
        end
        if (tick && elapsed != lps_pkg::ELAPSED_MAX)
            elapsed = elapsed + 1'b1;
        if (elapsed >= interval)
        begin
            elapsed = '0;
            step_pattern();
        end
        exp_item.leds   = leds;
        exp_item.mode_v = cur_mode;
        expected_q.push_back(exp_item);
    endfunction

    function void check_result(lps_pkg::led_t got_leds, lps_pkg::mode_t got_mode);
        lamp_state_t exp_item;
        if (expected_q.size() == 0)
        begin
            $error("unexpected result: led_bits %h mode %0d", got_leds, got_mode);
            errors++;
            return;
        end
        exp_item = expected_q.pop_front();
        if (got_leds !== exp_item.leds)
        begin
            $error("led_bits mismatch: expected %h, got %h", exp_item.leds, got_leds);
            errors++;
        end
        if (got_mode !== exp_item.mode_v)
        begin
            $error("mode mismatch: expected %0d, got %0d", exp_item.mode_v, got_mode);
            errors++;
        end
    endfunction
endclass

module tb_led_pattern_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lps_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       ms_tick;
    logic       press_event;
    logic       out_valid;
    logic       out_ready;
    led_t       led_bits;
    mode_t      mode;
    logic       cfg_wr_en;
    interval_t  cfg_wr_data;

    lamp_scoreboard sb = new();
    bit             idle_en = 1'b1;
    int             cycle_count = 0;

    led_pattern_sequencer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .ms_tick      (ms_tick),
        .press_event  (press_event),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .led_bits     (led_bits),
        .mode         (mode),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_item(ms_tick, press_event);
            if (out_valid && out_ready)
                sb.check_result(led_bits, mode);
        end
    end

    // output stalls
    initial
    begin
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    task automatic drive_item(input logic tick, input logic press);
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        ms_tick     <= tick;
        press_event <= press;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic program_interval(input interval_t v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_interval(v);
        @(posedge clk);
    endtask

    task automatic random_items(input int n, input int tick_pct, input int press_pct);
        repeat (n)
        begin
            drive_item($urandom_range(0, 99) < tick_pct, $urandom_range(0, 99) < press_pct);
        end
        drain();
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        ms_tick     <= 1'b0;
        press_event <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // before any press, default interval
        drive_item(1'b0, 1'b0);
        drive_item(1'b1, 1'b0);
        drain();

        // before any press, mode 0 still steps
        program_interval(16'd2);
        drive_item(1'b1, 1'b0);
        drive_item(1'b1, 1'b0);
        drive_item(1'b0, 1'b0);
        drive_item(1'b1, 1'b0);
        drive_item(1'b0, 1'b1);
        drain();

        // zero interval: every item steps; walk all modes through wrap
        program_interval(16'd0);
        repeat (9)
        begin
            drive_item(1'b0, 1'b1);
            drive_item(1'b1, 1'b0);
        end
        drain();

        program_interval(16'd1);
        random_items(80, 70, 10);

        program_interval(interval_t'($urandom_range(2, 6)));
        random_items(80, 80, 5);

        // count builds up, then the interval drops below it
        program_interval(16'hffff);
        random_items(100, 90, 10);
        program_interval(16'd5);
        random_items(40, 70, 8);

        // full-scale interval, never reached
        idle_en = 1'b0;
        program_interval(16'hffff);
        repeat (40) drive_item(1'b1, 1'b0);
        drain();

        idle_en = 1'b1;
        program_interval(interval_t'($urandom_range(1, 12)));
        random_items(80, 75, 12);

        idle_en = 1'b0;
        program_interval(interval_t'($urandom_range(1, 4)));
        random_items(60, 75, 10);

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
